// ===== rtl/core/sgs_pkg.sv =====
// shared types and constants of the sobel gradient stream block
package sgs_pkg;

    localparam int PIXEL_W    = 8;
    localparam int GRAD_W     = 9;
    localparam int PACKED_W   = 32;
    localparam int HALF_W     = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 11;
    localparam int SUM_W      = 11;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 8'd1;

    // frame size after reset, border excluded
    localparam int FRAME_WIDTH_RST  = 640;
    localparam int FRAME_HEIGHT_RST = 480;

    // position flags that travel with a pixel word
    typedef struct packed {
        logic emit;
        logic last;
    } t_pos;

    // one result word
    typedef struct packed {
        logic [GRAD_W-1:0] grad_x;
        logic [GRAD_W-1:0] grad_y;
        logic              frame_done;
    } t_result;

endpackage

// ===== rtl/core/sobel_gradient_3x3_stream_top.sv =====
// top level of the 3x3 sobel gradient stream over a bordered frame
//
//  channel  | direction | handshake                      | payload
//  ---------+-----------+--------------------------------+----------------------------------
//  pixel    | in        | i_pixel_valid / o_pixel_ready  | i_pixel
//  grad     | out       | o_grad_valid / i_grad_ready    | o_grad_x o_grad_y o_packed_word
//           |           |                                | o_frame_done
//  cfg      | in        | i_cfg_valid / o_cfg_ready      | i_cfg_index i_cfg_data
//
// One pixel word per cycle while o_pixel_ready is high. A word reads both line
// stores at its column in the accept cycle; in the next cycle the read data,
// the window and the new pixel give the result, the line store entry is written
// back and, for a word past the border, the result enters a three-entry queue.
// The line stores are not cleared by reset; counters, sizes and window are.
// The pixel side stalls only when the queue and the word in flight fill it.
module sobel_gradient_3x3_stream_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_pixel_valid,
    output logic                           o_pixel_ready,
    input  logic [sgs_pkg::PIXEL_W-1:0]    i_pixel,
    output logic                           o_grad_valid,
    input  logic                           i_grad_ready,
    output logic signed [sgs_pkg::GRAD_W-1:0] o_grad_x,
    output logic signed [sgs_pkg::GRAD_W-1:0] o_grad_y,
    output logic [sgs_pkg::PACKED_W-1:0]   o_packed_word,
    output logic                           o_frame_done,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [sgs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sgs_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sgs_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH + 2);
    localparam int RW    = $clog2(MAX_HEIGHT + 2);
    localparam int DEPTH = MAX_WIDTH + 2;
    localparam logic [CW-1:0] COL_LAST_RST =
        CW'(((FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RST) + 1);
    localparam logic [RW-1:0] ROW_LAST_RST =
        RW'(((FRAME_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : FRAME_HEIGHT_RST) + 1);

    logic [CW-1:0]      r_col_last;
    logic [RW-1:0]      r_row_last;
    logic [CW-1:0]      r_col;
    logic [RW-1:0]      r_row;
    logic [CW-1:0]      n_col;
    logic [RW-1:0]      n_row;
    logic [CW-1:0]      cfg_col_last;
    logic [RW-1:0]      cfg_row_last;
    logic               pix_fire;
    logic               cfg_fire;
    t_pos               pos;

    logic               r_s1_valid;
    logic [PIXEL_W-1:0] r_s1_pixel;
    logic [CW-1:0]      r_s1_col;
    t_pos               r_s1_pos;

    logic [PIXEL_W-1:0] rd_up;
    logic [PIXEL_W-1:0] rd_mid;
    logic               res_valid;
    t_result            res;
    logic [1:0]         q_count;
    t_result            q_data;

    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid;
    assign pix_fire    = i_pixel_valid & o_pixel_ready;

    // room in the queue for every word that may still produce a result
    assign o_pixel_ready = ({1'b0, q_count} + {2'b0, r_s1_valid}) <= 3'd2;

    // clamp written sizes into 1..max and keep the last padded index
    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_col_last = CW'(2);
        end else if (int'(i_cfg_data) > MAX_WIDTH) begin
            cfg_col_last = CW'(MAX_WIDTH + 1);
        end else begin
            cfg_col_last = CW'(i_cfg_data) + CW'(1);
        end
        if (i_cfg_data == '0) begin
            cfg_row_last = RW'(2);
        end else if (int'(i_cfg_data) > MAX_HEIGHT) begin
            cfg_row_last = RW'(MAX_HEIGHT + 1);
        end else begin
            cfg_row_last = RW'(i_cfg_data) + RW'(1);
        end
    end

    // position flags and next raster position
    always_comb begin
        pos.emit = (r_row >= RW'(2)) && (r_col >= CW'(2));
        pos.last = (r_row == r_row_last) && (r_col == r_col_last);
        if (r_col == r_col_last) begin
            n_col = '0;
            n_row = (r_row == r_row_last) ? '0 : r_row + RW'(1);
        end else begin
            n_col = r_col + CW'(1);
            n_row = r_row;
        end
    end

    // size registers and raster counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_last <= COL_LAST_RST;
            r_row_last <= ROW_LAST_RST;
            r_col      <= '0;
            r_row      <= '0;
        end else if (cfg_fire) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH: begin
                    r_col_last <= cfg_col_last;
                    r_col      <= '0;
                    r_row      <= '0;
                end
                CFG_FRAME_HEIGHT: begin
                    r_row_last <= cfg_row_last;
                    r_col      <= '0;
                    r_row      <= '0;
                end
                default: begin
                    r_col <= r_col;
                end
            endcase
        end else if (pix_fire) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // word in flight while the line store read completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= pix_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_fire) begin
            r_s1_pixel <= i_pixel;
            r_s1_col   <= r_col;
            r_s1_pos   <= pos;
        end
    end

    // line stores: read at accept, write back in the next cycle
    sgs_line_store #(
        .DEPTH (DEPTH),
        .AW    (CW)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rd_en   (pix_fire),
        .i_rd_addr (r_col),
        .o_rd_up   (rd_up),
        .o_rd_mid  (rd_mid),
        .i_wr_en   (r_s1_valid),
        .i_wr_addr (r_s1_col),
        .i_wr_up   (rd_mid),
        .i_wr_mid  (r_s1_pixel)
    );

    // window and gradient sums
    sgs_window_calc u_window_calc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_s1_valid),
        .i_pixel     (r_s1_pixel),
        .i_up        (rd_up),
        .i_mid       (rd_mid),
        .i_pos       (r_s1_pos),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // result queue
    sgs_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_count (q_count),
        .o_valid (o_grad_valid),
        .i_ready (i_grad_ready),
        .o_data  (q_data)
    );

    // output fields and the packed word
    assign o_grad_x      = signed'(q_data.grad_x);
    assign o_grad_y      = signed'(q_data.grad_y);
    assign o_frame_done  = q_data.frame_done;
    assign o_packed_word = {{(HALF_W - GRAD_W){q_data.grad_y[GRAD_W-1]}}, q_data.grad_y,
                            {(HALF_W - GRAD_W){q_data.grad_x[GRAD_W-1]}}, q_data.grad_x};

endmodule

// ===== rtl/core/sgs_line_store.sv =====
// two line stores kept side by side in one synchronous memory
module sgs_line_store #(
    parameter int DEPTH = 1026,
    parameter int AW    = 11
) (
    input  logic                       i_clk,
    input  logic                       i_rd_en,
    input  logic [AW-1:0]              i_rd_addr,
    output logic [sgs_pkg::PIXEL_W-1:0] o_rd_up,
    output logic [sgs_pkg::PIXEL_W-1:0] o_rd_mid,
    input  logic                       i_wr_en,
    input  logic [AW-1:0]              i_wr_addr,
    input  logic [sgs_pkg::PIXEL_W-1:0] i_wr_up,
    input  logic [sgs_pkg::PIXEL_W-1:0] i_wr_mid
);
    import sgs_pkg::*;

    logic [2*PIXEL_W-1:0] r_mem [DEPTH];
    logic [2*PIXEL_W-1:0] r_rd_data;

    // write port: upper line in the high byte, middle line in the low byte
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_up, i_wr_mid};
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_up  = r_rd_data[2*PIXEL_W-1:PIXEL_W];
    assign o_rd_mid = r_rd_data[PIXEL_W-1:0];

endmodule

// ===== rtl/core/sgs_window_calc.sv =====
// six-pixel window and the sobel sums for one pixel word
module sgs_window_calc (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [sgs_pkg::PIXEL_W-1:0] i_pixel,
    input  logic [sgs_pkg::PIXEL_W-1:0] i_up,
    input  logic [sgs_pkg::PIXEL_W-1:0] i_mid,
    input  sgs_pkg::t_pos               i_pos,
    output logic                        o_res_valid,
    output sgs_pkg::t_result            o_res
);
    import sgs_pkg::*;

    logic [PIXEL_W-1:0] r_win [6];
    logic [SUM_W-1:0]   x_pos;
    logic [SUM_W-1:0]   x_neg;
    logic [SUM_W-1:0]   y_pos;
    logic [SUM_W-1:0]   y_neg;
    logic [SUM_W-1:0]   x_diff;
    logic [SUM_W-1:0]   y_diff;

    // shift the window by one column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) begin
                r_win[k] <= '0;
            end
        end else if (i_valid) begin
            r_win[0] <= r_win[1];
            r_win[1] <= i_up;
            r_win[2] <= r_win[3];
            r_win[3] <= i_mid;
            r_win[4] <= r_win[5];
            r_win[5] <= i_pixel;
        end
    end

    // horizontal and vertical sums, wrapped to 11 bits two's complement
    always_comb begin
        x_pos  = {3'b0, i_up} + {2'b0, i_mid, 1'b0} + {3'b0, i_pixel};
        x_neg  = {3'b0, r_win[0]} + {2'b0, r_win[2], 1'b0} + {3'b0, r_win[4]};
        y_pos  = {3'b0, r_win[4]} + {2'b0, r_win[5], 1'b0} + {3'b0, i_pixel};
        y_neg  = {3'b0, r_win[0]} + {2'b0, r_win[1], 1'b0} + {3'b0, i_up};
        x_diff = x_pos - x_neg;
        y_diff = y_pos - y_neg;
    end

    // dropping the two low bits is the floor division by four
    assign o_res_valid      = i_valid & i_pos.emit;
    assign o_res.grad_x     = x_diff[SUM_W-1:2];
    assign o_res.grad_y     = y_diff[SUM_W-1:2];
    assign o_res.frame_done = i_pos.last;

endmodule

// ===== rtl/core/sgs_out_fifo.sv =====
// three-entry result queue in front of the output channel
module sgs_out_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  sgs_pkg::t_result i_data,
    output logic [1:0]       o_count,
    output logic             o_valid,
    input  logic             i_ready,
    output sgs_pkg::t_result o_data
);
    import sgs_pkg::*;

    t_result    r_buf [3];
    logic [1:0] r_wr_ptr;
    logic [1:0] r_rd_ptr;
    logic [1:0] r_count;
    logic       pop;

    assign pop     = (r_count != 2'd0) & i_ready;
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_buf[r_rd_ptr];
    assign o_count = r_count;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == 2'd2) ? 2'd0 : r_wr_ptr + 2'd1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == 2'd2) ? 2'd0 : r_rd_ptr + 2'd1;
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
